FILE: rtl/sm3_hash_engine_defines.svh
// ----------------------------------------------------------------------------
// SM3 assertion macros
// Concurrent assertion wrappers used by the SM3 port checker.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH
// Property with an implication that is checked on every rising clock edge outside reset.
`define SM3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that is also checked while reset is active.
`define SM3_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, types and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;
   localparam int unsigned NumCfg = 6;
   typedef enum logic [2:0] {
      CFG_USE_IV  = 3'd0,
      CFG_IV01    = 3'd1,
      CFG_IV23    = 3'd2,
      CFG_IV45    = 3'd3,
      CFG_IV67    = 3'd4,
      CFG_LEN_OFS = 3'd5
   } cfg_idx_type;

   typedef logic [7:0][31:0] state_type;

   localparam state_type StdIv = {
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};
   localparam logic [31:0] TjLow  = 32'h79CC4519;
   localparam logic [31:0] TjHigh = 32'h7A879D8A;
   localparam logic [31:0] PadOne = 32'h80000000;

   // Handshake between the sequencer and the compression unit.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } cmp_ctl_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0f(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1f(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction
endpackage

FILE: rtl/sm3_compress.sv
// ----------------------------------------------------------------------------
// SM3 compression unit
// One round per cycle over a 16-word expansion window; 64 rounds per block.
// ----------------------------------------------------------------------------
module sm3_compress (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0][31:0]    block,
   input  sm3_pkg::state_type   chain_in,
   output sm3_pkg::state_type   chain_out,
   output logic                 done
);
   import sm3_pkg::*;

   logic [15:0][31:0] win_ff, win_in;
   state_type         regs_ff, regs_in;
   logic [5:0]        round_ff, round_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   logic [31:0] wj, wj4, wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

   always_comb begin
      // window holds W[j..j+15]; wnew is W[j+16]
      wnew = p1f(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
             ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
      wj   = win_ff[0];
      wj4  = win_ff[4];
      tj   = (round_ff < 6'd16) ? TjLow : TjHigh;
      a12  = rotl(regs_ff[0], 5'd12);
      ss1  = rotl(a12 + regs_ff[4] + rotl(tj, round_ff[4:0]), 5'd7);
      ss2  = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff = regs_ff[0] ^ regs_ff[1] ^ regs_ff[2];
         gg = regs_ff[4] ^ regs_ff[5] ^ regs_ff[6];
      end else begin
         ff = (regs_ff[0] & regs_ff[1]) | (regs_ff[0] & regs_ff[2]) |
              (regs_ff[1] & regs_ff[2]);
         gg = (regs_ff[4] & regs_ff[5]) | (~regs_ff[4] & regs_ff[6]);
      end
      tt1 = ff + regs_ff[3] + ss2 + (wj ^ wj4);
      tt2 = gg + regs_ff[7] + ss1 + wj;

      win_in   = win_ff;
      regs_in  = regs_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         win_in   = block;
         regs_in  = chain_in;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         win_in     = {wnew, win_ff[15:1]};
         regs_in[3] = regs_ff[2];
         regs_in[2] = rotl(regs_ff[1], 5'd9);
         regs_in[1] = regs_ff[0];
         regs_in[0] = tt1;
         regs_in[7] = regs_ff[6];
         regs_in[6] = rotl(regs_ff[5], 5'd19);
         regs_in[5] = regs_ff[4];
         regs_in[4] = p0f(tt2);
         round_in   = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      regs_ff <= regs_in;
      if (reset) begin
         round_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         round_ff <= round_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign chain_out = regs_ff;
   assign done      = done_ff;
endmodule

FILE: rtl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streams a message in as 32-bit words, pads it and returns the 256-bit digest.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// req_    | in        | tdata: data_word[31:0], byte_count[34:32]; tlast: last_item
// rsp_    | out       | tdata: digest_word[31:0], word_index[34:32]; tlast: last_word
// csr_    | in        | write enable, index, 64-bit data
// Words are taken while req_tready is high; the 16th word of a block starts the
// round unit, and req_tready stays low until its rounds end and the chain is updated.
// After a last word the engine pushes the 0x80 word if owed and zero padding words,
// writes the length words and runs each padded block, then shows eight digest beats
// on rsp_, one per cycle while rsp_tready is high.
// Reset is synchronous; it clears control and configuration state and reloads the standard IV, no clearing pass.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word[31:0], byte_count[34:32], zeros
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zeros
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import sm3_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RUN, ST_PAD, ST_LEN, ST_WAIT, ST_OUT
   } phase_type;

   phase_type         phase_ff;
   logic              use_iv_ff;
   logic [3:0][63:0]  iv_ff;
   logic [63:0]       len_ofs_ff;
   state_type         chain_ff;
   logic [15:0][31:0] blk_ff;
   logic [3:0]        fill_ff;
   logic [63:0]       bits_ff;
   logic              pad_after_ff;  // push the 0x80 word once the block frees up
   logic              phase_pad_ff;  // padding in progress until the length block starts
   logic              final_ff;      // running block is the last one
   logic [2:0]        out_idx_ff;
   logic              start_ff, start_in;

   state_type   cmp_out;
   logic        cmp_done;

   logic [31:0] data_w;
   logic [2:0]  bcnt, bc;
   logic [31:0] keep, part, blk_word;
   logic [3:0]  push_fill;
   logic [63:0] bits_cur, add_bits;
   logic [63:0] msg_len;
   logic        req_take, pad_push;
   state_type   iv_sel;

   assign data_w = req_tdata[31:0];
   assign bcnt   = req_tdata[34:32];
   assign bc     = (bcnt > 3'd4) ? 3'd4 : bcnt;
   assign msg_len = bits_ff + len_ofs_ff;

   assign req_tready = (phase_ff == ST_IDLE) || (phase_ff == ST_RUN);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      keep = (bc == 3'd0) ? 32'h0 : (32'hFFFFFFFF << (6'd32 - {bc, 3'b000}));
      part = (data_w & keep) | (32'h80 << (5'd24 - {bc[1:0], 3'b000}));
      for (int i = 0; i < 4; i++) begin
         iv_sel[2*i]   = iv_ff[i][63:32];
         iv_sel[2*i+1] = iv_ff[i][31:0];
      end
      // first word of a message starts from an empty block and a zero length
      push_fill = (phase_ff == ST_IDLE) ? 4'd0 : fill_ff;
      bits_cur  = (phase_ff == ST_IDLE) ? 64'd0 : bits_ff;
      add_bits  = req_tlast ? {58'd0, bc, 3'b000} : 64'd32;
      pad_push  = (phase_ff == ST_PAD) && (pad_after_ff || fill_ff != 4'd14);
      if (phase_ff == ST_PAD) begin
         blk_word = pad_after_ff ? PadOne : 32'h0;
      end else begin
         blk_word = (req_tlast && bc != 3'd4) ? part : data_w;
      end
      // a word landing in slot 15 or the length words fire the round unit
      start_in = ((req_take || pad_push) && push_fill == 4'd15) || (phase_ff == ST_LEN);
   end

   sm3_compress u_cmp (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .block    (blk_ff),
      .chain_in (chain_ff),
      .chain_out(cmp_out),
      .done     (cmp_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         use_iv_ff    <= 1'b0;
         iv_ff        <= '0;
         len_ofs_ff   <= '0;
         chain_ff     <= StdIv;
         fill_ff      <= '0;
         bits_ff      <= '0;
         pad_after_ff <= 1'b0;
         phase_pad_ff <= 1'b0;
         final_ff     <= 1'b0;
         out_idx_ff   <= '0;
         start_ff     <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (start_in) final_ff <= (phase_ff == ST_LEN);
         if (csr_we) begin
            case (csr_index)
               CFG_USE_IV:  use_iv_ff  <= csr_wdata[0];
               CFG_IV01:    iv_ff[0]   <= csr_wdata;
               CFG_IV23:    iv_ff[1]   <= csr_wdata;
               CFG_IV45:    iv_ff[2]   <= csr_wdata;
               CFG_IV67:    iv_ff[3]   <= csr_wdata;
               CFG_LEN_OFS: len_ofs_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (phase_ff)
            ST_IDLE, ST_RUN: begin
               if (req_tvalid) begin
                  // first word of a message: load the chaining value
                  if (phase_ff == ST_IDLE) begin
                     chain_ff <= use_iv_ff ? iv_sel : StdIv;
                  end
                  blk_ff[push_fill] <= blk_word;
                  fill_ff           <= push_fill + 4'd1;
                  bits_ff           <= bits_cur + add_bits;
                  pad_after_ff      <= req_tlast && (bc == 3'd4);
                  phase_pad_ff      <= req_tlast;
                  if (push_fill == 4'd15) begin
                     phase_ff <= ST_WAIT;
                  end else if (req_tlast) begin
                     phase_ff <= ST_PAD;
                  end else begin
                     phase_ff <= ST_RUN;
                  end
               end
            end
            ST_PAD: begin
               // push the 0x80 word if owed, then zeros until fill reaches 14
               if (pad_push) begin
                  blk_ff[fill_ff] <= blk_word;
                  pad_after_ff    <= 1'b0;
                  fill_ff         <= fill_ff + 4'd1;
                  if (fill_ff == 4'd15) phase_ff <= ST_WAIT;
               end else begin
                  phase_ff <= ST_LEN;
               end
            end
            ST_LEN: begin
               blk_ff[14]   <= msg_len[63:32];
               blk_ff[15]   <= msg_len[31:0];
               fill_ff      <= '0;
               phase_pad_ff <= 1'b0;
               phase_ff     <= ST_WAIT;
            end
            ST_WAIT: begin
               if (cmp_done) begin
                  chain_ff <= chain_ff ^ cmp_out;
                  if (final_ff) begin
                     out_idx_ff <= '0;
                     phase_ff   <= ST_OUT;
                  end else if (phase_pad_ff) begin
                     phase_ff <= ST_PAD;
                  end else begin
                     phase_ff <= ST_RUN;
                  end
               end
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  out_idx_ff <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) phase_ff <= ST_IDLE;
               end
            end
            default: phase_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = (phase_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, out_idx_ff, chain_ff[out_idx_ff]};
   assign rsp_tlast  = (out_idx_ff == 3'd7);
endmodule

FILE: rtl/sm3_checker.sv
// ----------------------------------------------------------------------------
// SM3 port checker
// Watches the top-level ports of the hash engine.
// ----------------------------------------------------------------------------
`include "sm3_hash_engine_defines.svh"
module sm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   logic       rsp_beat;
   logic [2:0] rsp_idx;

   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign rsp_idx  = rsp_tdata[34:32];

   property p_idx_step;
      rsp_beat && !rsp_tlast |=> rsp_tvalid && rsp_idx == $past(rsp_idx) + 3'd1;
   endproperty

   property p_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty

   `SM3_ASSERT(a_no_req_during_rsp, clock, reset, rsp_tvalid |-> !req_tready, "ready in digest")
   `SM3_ASSERT(a_last_idx, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_idx == 3'd7, "bad tlast")
   `SM3_ASSERT(a_idx_step, clock, reset, p_idx_step, "digest index skipped")
   `SM3_ASSERT(a_hold, clock, reset, p_hold, "stalled beat changed")
   `SM3_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset |-> !rsp_tvalid, "beat at reset")
endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
